>>> rtl/core/crc16_pkg.sv
package crc16_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_INPUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_OUTPUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FINAL_XOR      = 3'd4;

    localparam logic [15:0] POLYNOMIAL_RESET     = 16'h1021;
    localparam logic [15:0] INITIAL_VALUE_RESET  = 16'h0000;
    localparam logic        REFLECT_INPUT_RESET  = 1'b1;
    localparam logic        REFLECT_OUTPUT_RESET = 1'b1;
    localparam logic [15:0] FINAL_XOR_RESET      = 16'h0000;
    localparam logic [15:0] CRC_RESET            = 16'h0000;
    localparam logic [15:0] CRC_TOP_BIT          = 16'h8000;

    typedef struct packed {
        logic [15:0] polynomial;
        logic [15:0] initial_value;
        logic        reflect_input;
        logic        reflect_output;
        logic [15:0] final_xor;
    } crc_cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       start;
        logic       last;
    } crc_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int k = 0; k < 16; k++) begin
            r[k] = v[15-k];
        end
        return r;
    endfunction

    function automatic logic [15:0] absorb_byte(input logic [15:0] crc,
                                                input logic [7:0]  b,
                                                input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP_BIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crc16_front.sv
module crc16_front
    import crc16_pkg::*;
(
    input  logic          aresetn,
    input  crc_cfg_t      cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_byte_present,
    input  logic          s_start_of_message,
    input  logic          s_end_of_message,
    input  queue_status_t q_status,
    output logic          q_wr,
    output crc_op_t       q_wr_op
);

    assign s_ready = aresetn && !q_status.full;
    assign q_wr    = s_valid && s_ready;

    // byte is put in msb-first order here so the back end never reflects an input byte
    always_comb begin
        q_wr_op.present = s_byte_present;
        q_wr_op.start   = s_start_of_message;
        q_wr_op.last    = s_end_of_message;
        if (!s_byte_present) begin
            q_wr_op.data = 8'h00;
        end else if (cfg.reflect_input) begin
            q_wr_op.data = rev8(s_data_byte);
        end else begin
            q_wr_op.data = s_data_byte;
        end
    end

endmodule

>>> rtl/core/crc16_queue.sv
module crc16_queue
    import crc16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr,
    input  crc_op_t       wr_op,
    input  logic          rd,
    output crc_op_t       rd_op,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crc_op_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_op        = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

>>> rtl/core/crc16_back.sv
module crc16_back
    import crc16_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  crc_cfg_t      cfg,
    input  queue_status_t q_status,
    input  crc_op_t       q_rd_op,
    output logic          q_rd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_crc_value
);

    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_crc_value_reg, m_crc_value_next;

    logic [15:0] crc_base;
    logic [15:0] crc_done;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    // an end request waits for the output slot, others pass straight through
    assign q_rd     = !q_status.empty && (!q_rd_op.last || out_free);

    always_comb begin
        crc_base = q_rd_op.start ? cfg.initial_value : crc_reg;
        crc_done = q_rd_op.present ? absorb_byte(crc_base, q_rd_op.data, cfg.polynomial)
                                   : crc_base;
        crc_next = q_rd ? crc_done : crc_reg;

        m_valid_next     = m_valid_reg;
        m_crc_value_next = m_crc_value_reg;
        if (q_rd && q_rd_op.last) begin
            m_valid_next     = 1'b1;
            m_crc_value_next = (cfg.reflect_output ? rev16(crc_done) : crc_done)
                               ^ cfg.final_xor;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_crc_value_reg <= m_crc_value_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = m_crc_value_reg;

endmodule

>>> rtl/core/crc16_configurable.sv
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------------------
// s_        | in        | s_valid / s_ready   | data_byte, byte_present, start/end_of_message
// m_        | out       | m_valid / m_ready   | crc_value
// cfg_      | in        | cfg_we              | cfg_index, cfg_wdata
//
// one request per cycle sustained while the queue is not full; the eight xor-shift steps
// of a byte run combinationally in the back end, and each result is held in a register
// a request queue of QUEUE_DEPTH entries lets requests keep arriving while a result waits
// synchronous active-low reset clears the queue, the crc register and the output slot
// only end requests wait on m_ready; byte requests go on while a result is held
module crc16_configurable
    import crc16_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_byte_present,
    input  logic                   s_start_of_message,
    input  logic                   s_end_of_message,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_crc_value
);

    crc_cfg_t      cfg_reg, cfg_next;
    queue_status_t q_status;
    logic          q_wr, q_rd;
    crc_op_t       q_wr_op, q_rd_op;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_POLYNOMIAL:     cfg_next.polynomial     = cfg_wdata;
                REG_INITIAL_VALUE:  cfg_next.initial_value  = cfg_wdata;
                REG_REFLECT_INPUT:  cfg_next.reflect_input  = cfg_wdata[0];
                REG_REFLECT_OUTPUT: cfg_next.reflect_output = cfg_wdata[0];
                REG_FINAL_XOR:      cfg_next.final_xor      = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial     <= POLYNOMIAL_RESET;
            cfg_reg.initial_value  <= INITIAL_VALUE_RESET;
            cfg_reg.reflect_input  <= REFLECT_INPUT_RESET;
            cfg_reg.reflect_output <= REFLECT_OUTPUT_RESET;
            cfg_reg.final_xor      <= FINAL_XOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crc16_front u_front (
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_byte_present     (s_byte_present),
        .s_start_of_message (s_start_of_message),
        .s_end_of_message   (s_end_of_message),
        .q_status           (q_status),
        .q_wr               (q_wr),
        .q_wr_op            (q_wr_op)
    );

    crc16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_op   (q_wr_op),
        .rd      (q_rd),
        .rd_op   (q_rd_op),
        .status  (q_status)
    );

    crc16_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_status    (q_status),
        .q_rd_op     (q_rd_op),
        .q_rd        (q_rd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_wr && q_status.full))
        else $error("queue written while full");

    a_no_read_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd |-> !q_status.empty)
        else $error("queue read while empty");

    a_accept_fills_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !q_status.empty)
        else $error("accepted request missing from queue");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_rd && q_rd_op.last) |=> m_valid)
        else $error("end request did not fill the output slot");

endmodule
